FILE: rtl/core/shcdf_pkg.sv
// Shared types and constants for the symbol histogram CDF builder.
`timescale 1ns / 1ps

package shcdf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CDF_W       = 16;
  localparam int PTR_W       = 9;
  localparam int SCALE_W     = 32;
  localparam int SYM_W       = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_BINS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE    = 2'd1;

  localparam logic REQ_TALLY = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [PTR_W-1:0]   NUM_BINS_RESET = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET    = 32'h0001_0000;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

FILE: rtl/core/symbol_histogram_cdf_builder.sv
// Top level: bin RAM histogram with scaled cumulative frequency readout.
`timescale 1ns / 1ps

// Usage
// - Command channel: a transaction is taken at a rising edge with start high and
//   busy low. req_type selects a tally (count symbol) or a readout (emit next
//   table entry).
// - Each item passes through the accept cycle and the execute state: the accept
//   cycle issues the bin RAM read and forms the scale product, the next cycle (busy
//   high) does the read-modify-write of the bin or the prefix update. No new item is
//   taken while busy is high, as the single-port bin RAM read is registered.
// - A readout result appears on cdf_value, entry_index and last_entry with done high
//   for exactly one cycle, registered at the end of the execute state. Tallies give
//   no result. The receiver cannot stall; results are never held.
// - After the entry flagged last_entry, bins, prefix and pointer clear at once
//   through per-bin valid bits; the next transaction may follow immediately.
// - Configuration: cfg_valid/cfg_ready write channel, always ready. Index 0 is
//   num_bins, index 1 is scale_q16 (unsigned Q16.16). Other indexes are ignored.
// - Reset (rst, synchronous): all bins, prefix and pointer zero, num_bins 256,
//   scale_q16 1.0; no clearing pass is needed.
module symbol_histogram_cdf_builder #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_WIDTH = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [shcdf_pkg::SYM_W-1:0]         symbol,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shcdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [shcdf_pkg::SCALE_W-1:0]       cfg_data,
  output logic                                done,
  output logic [shcdf_pkg::CDF_W-1:0]         cdf_value,
  output logic [shcdf_pkg::PTR_W-1:0]         entry_index,
  output logic                                last_entry
);

  localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CW = COUNT_WIDTH;
  localparam int PW = shcdf_pkg::PTR_W;
  localparam int VW = shcdf_pkg::CDF_W;
  localparam int PROD_W = CW + shcdf_pkg::SCALE_W;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
  localparam logic [PW-1:0] NSYM = PW'(NUM_SYMBOLS);

  shcdf_pkg::state_t state, state_next;

  logic [PW-1:0]                    num_bins;
  logic [shcdf_pkg::SCALE_W-1:0]    scale_q16;
  logic [CW-1:0]                    prefix_count;
  logic [PW-1:0]                    read_pointer;

  logic [CW-1:0]                    bin_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]           bin_valid;
  logic [CW-1:0]                    rd_data;
  logic                             rd_valid;
  logic [AW-1:0]                    op_addr;
  logic                             op_req;
  logic                             op_in_range;
  logic [shcdf_pkg::CDF_W-1:0]      prod_mid;

  logic                             accept;
  logic [AW-1:0]                    rd_addr;
  logic                             rd_in_range;
  logic [PROD_W-1:0]                product;
  logic [CW-1:0]                    cur_count;
  logic [PW-1:0]                    bins_in_use;
  logic                             is_last;
  logic [CW:0]                      prefix_sum;
  logic                             do_write;
  logic                             do_read_out;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    unique case (state)
      shcdf_pkg::ST_IDLE: state_next = accept ? shcdf_pkg::ST_EXEC : shcdf_pkg::ST_IDLE;
      shcdf_pkg::ST_EXEC: state_next = accept ? shcdf_pkg::ST_EXEC : shcdf_pkg::ST_IDLE;
      default:            state_next = shcdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      shcdf_pkg::ST_EXEC: busy = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shcdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins  <= shcdf_pkg::NUM_BINS_RESET;
      scale_q16 <= shcdf_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == shcdf_pkg::CFG_NUM_BINS) begin
        num_bins <= cfg_data[PW-1:0];
      end else if (cfg_index == shcdf_pkg::CFG_SCALE) begin
        scale_q16 <= cfg_data;
      end
    end
  end

  // Issue stage
  always_comb begin
    if (req_type == shcdf_pkg::REQ_READ) begin
      rd_addr     = read_pointer[AW-1:0];
      rd_in_range = read_pointer < NSYM;
    end else begin
      rd_addr     = symbol[AW-1:0];
      rd_in_range = PW'(symbol) < NSYM;
    end
  end

  assign product = PROD_W'(prefix_count) * PROD_W'(scale_q16);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data     <= bin_mem[rd_addr];
      rd_valid    <= bin_valid[rd_addr];
      op_addr     <= rd_addr;
      op_req      <= req_type;
      op_in_range <= rd_in_range;
      prod_mid    <= product[31:16];
    end
  end

  // Execute stage
  always_comb begin
    cur_count = rd_valid ? rd_data : '0;
    if (num_bins == '0) begin
      bins_in_use = PW'(1);
    end else if (num_bins > NSYM) begin
      bins_in_use = NSYM;
    end else begin
      bins_in_use = num_bins;
    end
    is_last     = read_pointer >= bins_in_use;
    prefix_sum  = {1'b0, prefix_count} + {1'b0, (op_in_range ? cur_count : CW'(0))};
    do_write    = busy && (op_req == shcdf_pkg::REQ_TALLY) && op_in_range
                  && (cur_count != COUNT_MAX);
    do_read_out = busy && (op_req == shcdf_pkg::REQ_READ);
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      bin_mem[op_addr] <= cur_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid    <= '0;
      prefix_count <= '0;
      read_pointer <= '0;
      done         <= 1'b0;
    end else begin
      done <= do_read_out;
      if (do_write) begin
        bin_valid[op_addr] <= 1'b1;
      end
      if (do_read_out) begin
        if (is_last) begin
          bin_valid    <= '0;
          prefix_count <= '0;
          read_pointer <= '0;
        end else begin
          prefix_count <= prefix_sum[CW] ? COUNT_MAX : prefix_sum[CW-1:0];
          read_pointer <= read_pointer + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_read_out) begin
      cdf_value   <= prod_mid + VW'(read_pointer);
      entry_index <= read_pointer;
      last_entry  <= is_last;
    end
  end

  a_done_from_readout: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy && op_req == shcdf_pkg::REQ_READ))
    else $error("result strobe without a readout in execute");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(start && !busy)) |-> 1'b0)
    else $error("execute stage held without an accepted transaction");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (done && last_entry) |-> (read_pointer == '0 && prefix_count == '0 && bin_valid == '0))
    else $error("store not cleared after final entry");

  a_pointer_advance: assert property (@(posedge clk) disable iff (rst)
    (done && !last_entry) |-> (read_pointer == PW'(entry_index + PW'(1))))
    else $error("read pointer did not advance past emitted entry");

endmodule
